@@ design/isd_pkg.sv @@
// Shared types and constants for the isochronous stream packet demux.
package isd_pkg;

   // Stream marker that opens every header
   localparam logic [7:0] SYNC_BYTE = 8'hFA;
   // Payload size of a video packet
   localparam logic [7:0] VIDEO_SIZE = 8'd180;
   // Saturation limit of the frame byte count
   localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;
   // Payload size a bad header skips
   localparam logic [7:0] BAD_SKIP = 8'd3;
   // Payload size that may hide a new header
   localparam logic [7:0] RETRY_SIZE = 8'd4;

   // Header flag bit positions within the 24-bit header word
   localparam int unsigned UNK_BIT   = 4;
   localparam int unsigned SYNC_BIT  = 5;
   localparam int unsigned AUDIO_BIT = 6;

   // Result kinds
   localparam logic [1:0] KIND_AUDIO     = 2'd0;
   localparam logic [1:0] KIND_VIDEO     = 2'd1;
   localparam logic [1:0] KIND_FRAME_END = 2'd2;
   localparam logic [1:0] KIND_BAD_HDR   = 2'd3;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_AUDIO_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_VIDEO_ENABLE   = 2'd1;
   localparam logic [1:0] CSR_VIDEO_CAPACITY = 2'd2;

   // Reset value of the video capacity register
   localparam logic [23:0] CAPACITY_RESET = 24'd65536;

   // Packet classes
   typedef enum logic [1:0] {
      CLS_DROP  = 2'd0,
      CLS_SYNC  = 2'd1,
      CLS_AUDIO = 2'd2,
      CLS_VIDEO = 2'd3
   } pkt_class_type;

   // One result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        last_of_packet;
      logic [23:0] frame_bytes;
   } result_type;

endpackage

@@ design/isoc_stream_packet_demux.sv @@
// Top level of the isochronous stream packet demux: header parse, classify, forward.
//
// A result enters the result buffer when the byte that causes it is accepted.
// Throughput: one stream byte per cycle while not stalled; all per-byte work is one pass
// of counter and compare logic into the state registers and a two-entry result buffer.
// req_stall rises only while both result buffer entries are full.
// Reset (synchronous, active high) clears parser state, sync, counters and enables.
module isoc_stream_packet_demux
   import isd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // stream byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_of_packet,
   output logic [23:0] rsp_frame_bytes,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   // Configuration registers
   logic        audio_enable_ff;
   logic        video_enable_ff;
   logic [23:0] video_capacity_ff;

   // Parser state
   logic [23:0]   header_store_ff, header_store_in;
   logic [1:0]    header_index_ff, header_index_in;
   logic          in_payload_ff, in_payload_in;
   logic [7:0]    payload_left_ff, payload_left_in;
   pkt_class_type packet_class_ff, packet_class_in;
   logic          retry_candidate_ff, retry_candidate_in;
   logic          video_pass_ff, video_pass_in;
   logic          synced_ff, synced_in;
   logic [23:0]   video_count_ff, video_count_in;

   // Result buffer
   result_type  slot_ff [2];
   logic [1:0]  fill_ff;
   result_type  res_in;
   logic        res_push;
   logic        res_pop;

   logic        req_accept;
   logic        csr_accept;

   // Helpers
   logic [23:0]   hdr_word;
   logic [7:0]    hdr_size;
   pkt_class_type hdr_class;
   logic [24:0]   video_sum;
   logic [23:0]   video_sum_sat;
   logic [7:0]    left_dec;
   logic          is_last;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (fill_ff == 2'd2);
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign rsp_valid = (fill_ff != 2'd0);
   assign res_pop   = rsp_valid && !rsp_stall;

   assign rsp_kind           = slot_ff[0].kind;
   assign rsp_data_byte      = slot_ff[0].data_byte;
   assign rsp_last_of_packet = slot_ff[0].last_of_packet;
   assign rsp_frame_bytes    = slot_ff[0].frame_bytes;

   // Decode the header word completed by the current byte
   assign hdr_word = {header_store_ff[15:0], req_stream_byte};
   assign hdr_size = {hdr_word[9:8], hdr_word[23:20], 2'b00};

   always_comb begin
      if (hdr_word[UNK_BIT]) begin
         hdr_class = CLS_DROP;
      end else if (hdr_word[SYNC_BIT]) begin
         hdr_class = CLS_SYNC;
      end else if (hdr_word[AUDIO_BIT]) begin
         hdr_class = CLS_AUDIO;
      end else if (hdr_size == VIDEO_SIZE) begin
         hdr_class = CLS_VIDEO;
      end else begin
         hdr_class = CLS_DROP;
      end
   end

   // Frame count plus one video packet, and its saturated form
   assign video_sum     = {1'b0, video_count_ff} + {17'd0, VIDEO_SIZE};
   assign video_sum_sat = video_sum[24] ? COUNT_MAX : video_sum[23:0];

   assign left_dec = (payload_left_ff != 8'd0) ? (payload_left_ff - 8'd1) : 8'd0;
   assign is_last  = (left_dec == 8'd0);

   // Next parser state and result for one accepted byte
   always_comb begin
      header_store_in    = header_store_ff;
      header_index_in    = header_index_ff;
      in_payload_in      = in_payload_ff;
      payload_left_in    = payload_left_ff;
      packet_class_in    = packet_class_ff;
      retry_candidate_in = retry_candidate_ff;
      video_pass_in      = video_pass_ff;
      synced_in          = synced_ff;
      video_count_in     = video_count_ff;
      res_push           = 1'b0;
      res_in             = '0;

      if (req_accept) begin
         if (in_payload_ff) begin
            retry_candidate_in = 1'b0;
            if (retry_candidate_ff && (req_stream_byte == SYNC_BYTE)) begin
               // restart as a new header
               in_payload_in   = 1'b0;
               payload_left_in = 8'd0;
               header_store_in = 24'd0;
               header_index_in = 2'd1;
            end else begin
               payload_left_in = left_dec;
               if (is_last) begin
                  in_payload_in = 1'b0;
               end
               case (packet_class_ff)
                  CLS_AUDIO: begin
                     if (synced_ff && audio_enable_ff) begin
                        res_push              = 1'b1;
                        res_in.kind           = KIND_AUDIO;
                        res_in.data_byte      = req_stream_byte;
                        res_in.last_of_packet = is_last;
                     end
                  end
                  CLS_VIDEO: begin
                     if (is_last) begin
                        video_count_in = video_sum_sat;
                     end
                     if (video_pass_ff) begin
                        res_push              = 1'b1;
                        res_in.kind           = KIND_VIDEO;
                        res_in.data_byte      = req_stream_byte;
                        res_in.last_of_packet = is_last;
                     end
                  end
                  CLS_SYNC: begin
                     if (is_last) begin
                        // close the frame; count only matters once synced
                        synced_in      = 1'b1;
                        video_count_in = 24'd0;
                        if (synced_ff && (video_count_ff != 24'd0) && video_enable_ff) begin
                           res_push              = 1'b1;
                           res_in.kind           = KIND_FRAME_END;
                           res_in.last_of_packet = 1'b1;
                           res_in.frame_bytes    = video_count_ff;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else if (header_index_ff == 2'd0) begin
            if (req_stream_byte != SYNC_BYTE) begin
               // bad marker: report and skip three bytes
               in_payload_in      = 1'b1;
               payload_left_in    = BAD_SKIP;
               packet_class_in    = CLS_DROP;
               retry_candidate_in = 1'b0;
               video_pass_in      = 1'b0;
               res_push           = 1'b1;
               res_in.kind        = KIND_BAD_HDR;
            end else begin
               header_store_in = 24'd0;
               header_index_in = 2'd1;
            end
         end else begin
            header_store_in = hdr_word;
            if (header_index_ff != 2'd3) begin
               header_index_in = header_index_ff + 2'd1;
            end else begin
               header_index_in = 2'd0;
               if (hdr_size != 8'd0) begin
                  packet_class_in    = hdr_class;
                  retry_candidate_in = (hdr_size == RETRY_SIZE);
                  video_pass_in      = (hdr_class == CLS_VIDEO) && synced_ff &&
                                       video_enable_ff &&
                                       (video_sum < {1'b0, video_capacity_ff});
                  in_payload_in      = 1'b1;
                  payload_left_in    = hdr_size;
               end
            end
         end
      end
   end

   // Hold configuration and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         audio_enable_ff    <= 1'b0;
         video_enable_ff    <= 1'b0;
         video_capacity_ff  <= CAPACITY_RESET;
         header_store_ff    <= 24'd0;
         header_index_ff    <= 2'd0;
         in_payload_ff      <= 1'b0;
         payload_left_ff    <= 8'd0;
         packet_class_ff    <= CLS_DROP;
         retry_candidate_ff <= 1'b0;
         video_pass_ff      <= 1'b0;
         synced_ff          <= 1'b0;
         video_count_ff     <= 24'd0;
      end else begin
         if (csr_accept) begin
            case (csr_index)
               CSR_AUDIO_ENABLE:   audio_enable_ff   <= csr_wdata[0];
               CSR_VIDEO_ENABLE:   video_enable_ff   <= csr_wdata[0];
               CSR_VIDEO_CAPACITY: video_capacity_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         header_store_ff    <= header_store_in;
         header_index_ff    <= header_index_in;
         in_payload_ff      <= in_payload_in;
         payload_left_ff    <= payload_left_in;
         packet_class_ff    <= packet_class_in;
         retry_candidate_ff <= retry_candidate_in;
         video_pass_ff      <= video_pass_in;
         synced_ff          <= synced_in;
         video_count_ff     <= video_count_in;
      end
   end

   // Result buffer fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_ff + {1'b0, res_push} - {1'b0, res_pop};
      end
   end

   // Result buffer entries: advance on transfer, load new results behind
   always_ff @(posedge clock) begin
      case (fill_ff)
         2'd0: begin
            if (res_push) begin
               slot_ff[0] <= res_in;
            end
         end
         2'd1: begin
            if (res_push && res_pop) begin
               slot_ff[0] <= res_in;
            end else if (res_push) begin
               slot_ff[1] <= res_in;
            end
         end
         2'd2: begin
            if (res_pop) begin
               slot_ff[0] <= slot_ff[1];
            end
         end
         default: begin
         end
      endcase
   end

   // Buffer never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("result buffer overflow");

   // A pushed result into an empty buffer is offered next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (res_push && fill_ff == 2'd0) |=> rsp_valid)
      else $error("pushed result not offered");

   // Bad header only reported at the start of a header
   a_bad_at_start: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_in.kind == KIND_BAD_HDR) |-> (!in_payload_ff && header_index_ff == 2'd0))
      else $error("bad header outside header start");

   // Frame end carries a nonzero count and clears it
   a_frame_end_count: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_in.kind == KIND_FRAME_END) |=>
      (video_count_ff == 24'd0 && synced_ff && $past(video_count_ff) != 24'd0))
      else $error("frame end with bad count");

endmodule

@@ bench/isoc_stream_packet_demux_tb.sv @@
// Self-checking testbench for the isochronous stream packet demux.
`timescale 1ns / 1ps

module isoc_stream_packet_demux_tb
   import isd_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_of_packet;
   logic [23:0] rsp_frame_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [23:0] csr_wdata = 24'd0;

   isoc_stream_packet_demux dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_frame_bytes    (rsp_frame_bytes),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stream bytes waiting to be sent, and results the demux still owes
   logic [7:0]  byte_backlog[$];
   result_type  demux_results_due[$];

   // Shadow copy of the register file
   logic        aud_en = 1'b0;
   logic        vid_en = 1'b0;
   logic [23:0] vid_cap = CAPACITY_RESET;

   // Shadow copy of the parser state
   logic [23:0]   hdr_bytes = 24'd0;
   logic [1:0]    hdr_pos = 2'd0;
   logic          in_body = 1'b0;
   logic [7:0]    body_left = 8'd0;
   pkt_class_type body_class = CLS_DROP;
   logic          may_retry = 1'b0;
   logic          video_fwd = 1'b0;
   logic          locked = 1'b0;
   logic [23:0]   frame_count = 24'd0;

   int error_count = 0;
   int bytes_queued = 0;
   int bytes_sent = 0;
   int settings_run = 0;
   int drains_done = 0;
   int kind_seen[4] = '{0, 0, 0, 0};
   int results_seen = 0;

   task automatic report_mismatch(input string msg);
      if (error_count < 50)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void owe_result(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last, input logic [23:0] count);
      result_type r;
      r.kind = kind;
      r.data_byte = data;
      r.last_of_packet = last;
      r.frame_bytes = count;
      demux_results_due.push_back(r);
   endfunction

   // Advance the shadow parser by one stream byte and record any result it owes
   function automatic void parse_stream_byte(input logic [7:0] b);
      logic          retry_now;
      logic          last;
      logic [23:0]   count;
      logic [24:0]   sum;
      logic [7:0]    len;
      pkt_class_type cls;
      if (in_body) begin
         retry_now = may_retry;
         may_retry = 1'b0;
         if (retry_now && b == SYNC_BYTE) begin
            // size-4 payload that opens with the marker restarts a header
            in_body = 1'b0;
            body_left = 8'd0;
            hdr_bytes = 24'd0;
            hdr_pos = 2'd1;
         end else begin
            body_left = (body_left != 8'd0) ? body_left - 8'd1 : 8'd0;
            last = (body_left == 8'd0);
            if (last)
               in_body = 1'b0;
            case (body_class)
               CLS_AUDIO: begin
                  if (locked && aud_en)
                     owe_result(KIND_AUDIO, b, last, 24'd0);
               end
               CLS_VIDEO: begin
                  if (last) begin
                     sum = {1'b0, frame_count} + {17'd0, VIDEO_SIZE};
                     frame_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[23:0];
                  end
                  if (video_fwd)
                     owe_result(KIND_VIDEO, b, last, 24'd0);
               end
               CLS_SYNC: begin
                  if (last) begin
                     if (!locked)
                        frame_count = 24'd0;
                     locked = 1'b1;
                     count = frame_count;
                     if (count != 24'd0) begin
                        frame_count = 24'd0;
                        if (vid_en)
                           owe_result(KIND_FRAME_END, 8'd0, 1'b1, count);
                     end
                  end
               end
               default: ;
            endcase
         end
      end else if (hdr_pos == 2'd0) begin
         if (b != SYNC_BYTE) begin
            // bad marker: report and skip the rest of the word
            in_body = 1'b1;
            body_left = BAD_SKIP;
            body_class = CLS_DROP;
            may_retry = 1'b0;
            video_fwd = 1'b0;
            owe_result(KIND_BAD_HDR, 8'd0, 1'b0, 24'd0);
         end else begin
            hdr_bytes = 24'd0;
            hdr_pos = 2'd1;
         end
      end else begin
         hdr_bytes = {hdr_bytes[15:0], b};
         if (hdr_pos != 2'd3) begin
            hdr_pos = hdr_pos + 2'd1;
         end else begin
            hdr_pos = 2'd0;
            len = {hdr_bytes[9:8], hdr_bytes[23:20], 2'b00};
            if (len != 8'd0) begin
               // classify by flag priority, then by size
               if (hdr_bytes[UNK_BIT])
                  cls = CLS_DROP;
               else if (hdr_bytes[SYNC_BIT])
                  cls = CLS_SYNC;
               else if (hdr_bytes[AUDIO_BIT])
                  cls = CLS_AUDIO;
               else if (len == VIDEO_SIZE)
                  cls = CLS_VIDEO;
               else
                  cls = CLS_DROP;
               body_class = cls;
               may_retry = (len == RETRY_SIZE);
               video_fwd = (cls == CLS_VIDEO) && locked && vid_en &&
                           (({1'b0, frame_count} + {17'd0, VIDEO_SIZE}) < {1'b0, vid_cap});
               in_body = 1'b1;
               body_left = len;
            end
         end
      end
   endfunction

   // Driver: send the backlog in bursts with gaps, and drain now and then
   int burst_left = 1;
   int gap_left = 0;
   int burst_count = 0;
   logic drain_wait = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_stream_byte(req_stream_byte);
            bytes_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (drain_wait) begin
            req_valid <= 1'b0;
            if (demux_results_due.size() == 0) begin
               drain_wait = 1'b0;
               drains_done++;
            end
         end else if (byte_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_stream_byte <= byte_backlog.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_count++;
               if ($urandom_range(0, 7) == 0) begin
                  burst_left = $urandom_range(150, 300);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
               drain_wait = (burst_count % 16 == 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result transfer and drive the output stall pattern
   int cycle_count = 0;
   int stall_mode = 0;
   int stall_run = 0;
   result_type got, want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind;
         got.data_byte = rsp_data_byte;
         got.last_of_packet = rsp_last_of_packet;
         got.frame_bytes = rsp_frame_bytes;
         results_seen++;
         kind_seen[got.kind]++;
         if (demux_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %0h",
                                      got.kind, got.data_byte));
         end else begin
            want = demux_results_due.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                         results_seen, got.kind, want.kind));
            if (got.data_byte !== want.data_byte)
               report_mismatch($sformatf("result %0d data_byte %0h, want %0h",
                                         results_seen, got.data_byte, want.data_byte));
            if (got.last_of_packet !== want.last_of_packet)
               report_mismatch($sformatf("result %0d last_of_packet %0b, want %0b",
                                         results_seen, got.last_of_packet,
                                         want.last_of_packet));
            if (got.frame_bytes !== want.frame_bytes)
               report_mismatch($sformatf("result %0d frame_bytes %0d, want %0d",
                                         results_seen, got.frame_bytes, want.frame_bytes));
         end
      end
      // pick a new stall style when cycle_count wraps its period, then drive rsp_stall in it
      cycle_count++;
      if (cycle_count % 128 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ((cycle_count % 8) < 3);
         default: begin
            if (stall_run != 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 3) == 0)
                  stall_run = $urandom_range(5, 20);
            end
         end
      endcase
   end

   task automatic push_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
      bytes_queued++;
   endtask

   // Queue a header for the given size and class, then sent payload bytes
   task automatic add_packet(input logic [7:0] len, input pkt_class_type cls,
                             input logic unk, input logic [7:0] sent, input logic lead_fa);
      logic [7:0] b1, b2, b3;
      b1 = {len[5:2], 4'($urandom)};
      b2 = {6'($urandom), len[7:6]};
      b3 = 8'($urandom);
      b3[UNK_BIT] = unk;
      if (!unk) begin
         b3[SYNC_BIT] = (cls == CLS_SYNC);
         if (cls != CLS_SYNC)
            b3[AUDIO_BIT] = (cls == CLS_AUDIO);
      end
      push_byte(SYNC_BYTE);
      push_byte(b1);
      push_byte(b2);
      push_byte(b3);
      for (int i = 0; i < sent; i++)
         push_byte((lead_fa && i == 0) ? SYNC_BYTE : 8'($urandom));
   endtask

   // Queue mostly well-formed packet sequences, with noise and broken packets mixed in
   task automatic build_stream(input int budget);
      int start;
      int pick;
      logic [7:0] len;
      logic [7:0] b1, b2, b3;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 63) << 2)
                                              : 8'($urandom_range(1, 4) << 2);
            add_packet(len, CLS_SYNC, 1'b0, len, 1'b0);
         end else if (pick < 36) begin
            add_packet(VIDEO_SIZE, CLS_VIDEO, 1'b0, VIDEO_SIZE, 1'b0);
         end else if (pick < 62) begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 63) << 2)
                                              : 8'($urandom_range(1, 16) << 2);
            add_packet(len, CLS_AUDIO, 1'b0, len, 1'b0);
         end else if (pick < 68) begin
            len = 8'($urandom_range(1, 63) << 2);
            add_packet(len, pkt_class_type'($urandom_range(0, 3)), 1'b1, len, 1'b0);
         end else if (pick < 74) begin
            len = 8'($urandom_range(1, 63) << 2);
            if (len == VIDEO_SIZE)
               len = VIDEO_SIZE + RETRY_SIZE;
            add_packet(len, CLS_DROP, 1'b0, len, 1'b0);
         end else if (pick < 78) begin
            add_packet(8'd0, pkt_class_type'($urandom_range(0, 3)), 1'($urandom), 8'd0, 1'b0);
         end else if (pick < 84) begin
            // header only; the next packet's marker lands as the first payload byte
            add_packet(RETRY_SIZE, pkt_class_type'($urandom_range(0, 3)), 1'b0, 8'd0, 1'b0);
         end else if (pick < 88) begin
            add_packet(VIDEO_SIZE, CLS_VIDEO, 1'b0, 8'($urandom_range(0, 44) << 2), 1'b0);
         end else if (pick < 94) begin
            repeat (($urandom_range(0, 1) + 1) * 4)
               push_byte(8'($urandom));
         end else begin
            b1 = 8'($urandom);
            b2 = 8'($urandom);
            b3 = 8'($urandom);
            len = {b2[1:0], b1[7:4], 2'b00};
            push_byte(SYNC_BYTE);
            push_byte(b1);
            push_byte(b2);
            push_byte(b3);
            for (int i = 0; i < len; i++)
               push_byte(8'($urandom));
         end
      end
   endtask

   // Wait until every byte is sent and every owed result has come back
   task automatic wait_idle();
      do
         @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || demux_results_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_AUDIO_ENABLE:   aud_en = value[0];
         CSR_VIDEO_ENABLE:   vid_en = value[0];
         CSR_VIDEO_CAPACITY: vid_cap = value;
         default: ;
      endcase
   endtask

   // Register settings for the random phases
   logic        set_aud[6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
   logic        set_vid[6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   logic [23:0] set_cap[6] = '{24'hFF_FFFF, 24'd181, 24'd0, 24'd65536, 24'd541, 24'd0};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: bad markers, skipped marker, empty payload, header retry
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(SYNC_BYTE);
      push_byte(8'h12);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      add_packet(8'd0, CLS_DROP, 1'b1, 8'd0, 1'b0);
      add_packet(RETRY_SIZE, CLS_SYNC, 1'b0, 8'd0, 1'b0);
      add_packet(RETRY_SIZE, CLS_SYNC, 1'b0, RETRY_SIZE, 1'b0);
      build_stream(60);
      wait_idle();
      settings_run++;

      // Random phases, one per register setting
      for (int p = 0; p < 6; p++) begin
         csr_write(CSR_AUDIO_ENABLE, {23'd0, set_aud[p]});
         csr_write(CSR_VIDEO_ENABLE, {23'd0, set_vid[p]});
         csr_write(CSR_VIDEO_CAPACITY,
                   (p == 5) ? 24'($urandom_range(0, 2000)) : set_cap[p]);
         repeat (2) @(negedge clock);
         build_stream(170);
         wait_idle();
         settings_run++;
      end

      repeat (10) @(posedge clock);
      if (demux_results_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", demux_results_due.size()));
      $display("Run covered %0d stream bytes under %0d register settings, %0d drains",
               bytes_sent, settings_run, drains_done);
      $display("Checked %0d audio, %0d video, %0d frame end, %0d bad header results",
               kind_seen[KIND_AUDIO], kind_seen[KIND_VIDEO], kind_seen[KIND_FRAME_END],
               kind_seen[KIND_BAD_HDR]);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
